// ===== rtl/lcd_mode_timing_top_defines.svh =====
// Assertion macros for the LCD mode timing checker.
`ifndef LCD_MODE_TIMING_TOP_DEFINES_SVH
`define LCD_MODE_TIMING_TOP_DEFINES_SVH

// Check a property at every rising clock edge outside reset.
`define LMT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition at one edge implies a consequence at the next edge.
`define LMT_ASSERT_NEXT(label, cond, conseq, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
        else $error(msg);

`endif

// ===== rtl/lmt_pkg.sv =====
`default_nettype none

package lmt_pkg;

    typedef enum logic [1:0] {
        MODE_HBLANK = 2'd0,
        MODE_VBLANK = 2'd1,
        MODE_OAM    = 2'd2,
        MODE_XFER   = 2'd3
    } lcd_mode_t;

    localparam int unsigned DOT_W  = 10;
    localparam int unsigned LINE_W = 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [DOT_W-1:0] DOTS_OAM    = 10'd80;
    localparam logic [DOT_W-1:0] DOTS_XFER   = 10'd172;
    localparam logic [DOT_W-1:0] DOTS_HBLANK = 10'd204;
    localparam logic [DOT_W-1:0] DOTS_LINE   = 10'd456;

    localparam logic [LINE_W-1:0] LINE_VBLANK = 8'd144;
    localparam logic [LINE_W-1:0] LINE_WRAP   = 8'd153;
    localparam logic [LINE_W-1:0] LINE_FIRST  = 8'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_LCD_ENABLE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HBLANK_IRQ_ENABLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_IRQ_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OAM_IRQ_ENABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_IRQ_EN    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPARE_LINE      = 3'd5;

endpackage

`default_nettype wire

// ===== rtl/lmt_if.sv =====
`default_nettype none

interface lmt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] elapsed_cycles;

    modport source (output valid, output elapsed_cycles, input ready);
    modport sink (input valid, input elapsed_cycles, output ready);
endinterface

interface lmt_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] lcd_mode;
    logic [7:0] current_line;
    logic       coincidence;
    logic       vblank_irq;
    logic       stat_irq;
    logic       draw_line;

    modport source (
        output valid, output lcd_mode, output current_line, output coincidence,
        output vblank_irq, output stat_irq, output draw_line, input ready
    );
    modport sink (
        input valid, input lcd_mode, input current_line, input coincidence,
        input vblank_irq, input stat_irq, input draw_line, output ready
    );
endinterface

interface lmt_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/lcd_mode_timing_top.sv =====
// LCD mode timing generator.
// Channel in_ch carries elapsed machine cycles; each transaction advances the
// dot counter and steps the OAM search / transfer / HBlank / VBlank sequence.
// Channel out_ch returns exactly one result per input transaction: mode,
// current line, coincidence flag and the VBlank, status and draw pulses.
// Channel cfg writes the enable bits and the compare line; it is always
// ready. It must be written only while no transaction is in flight; the block does not enforce this.
// The result is registered and is valid the cycle after its input is accepted.
// Throughput: one transaction per cycle while out_ch is not stalled, set by the single update
// stage that sits between the timing state registers and the result register.
// When out_ch stalls, the result register holds and in_ch stays ready only
// if that result is taken in the same cycle.
// Reset clears the timing state, the configuration (display off) and the
// result valid flag.
`default_nettype none

module lcd_mode_timing_top
    import lmt_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    lmt_in_if.sink     in_ch,
    lmt_out_if.source  out_ch,
    lmt_cfg_if.sink    cfg
);

    logic              lcd_enable_reg;
    logic              hblank_irq_en_reg;
    logic              vblank_irq_en_reg;
    logic              oam_irq_en_reg;
    logic              compare_irq_en_reg;
    logic [LINE_W-1:0] compare_line_reg;

    logic [DOT_W-1:0]  dot_count_reg,  dot_count_next;
    logic [LINE_W-1:0] line_count_reg, line_count_next;
    lcd_mode_t         mode_reg,       mode_next;
    logic              coinc_reg,      coinc_next;

    logic              out_valid_reg;
    lcd_mode_t         out_mode_reg;
    logic [LINE_W-1:0] out_line_reg;
    logic              out_coinc_reg;
    logic              out_vblank_reg, vblank_next;
    logic              out_stat_reg,   stat_next;
    logic              out_draw_reg,   draw_next;

    logic              in_fire;
    logic [DOT_W-1:0]  dot_sum;
    logic [LINE_W-1:0] line_inc;
    logic              match_inc;
    logic              match_zero;

    assign cfg.ready   = 1'b1;
    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign in_fire     = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcd_enable_reg     <= 1'b0;
            hblank_irq_en_reg  <= 1'b0;
            vblank_irq_en_reg  <= 1'b0;
            oam_irq_en_reg     <= 1'b0;
            compare_irq_en_reg <= 1'b0;
            compare_line_reg   <= '0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_LCD_ENABLE:        lcd_enable_reg     <= cfg.data[0];
                CFG_HBLANK_IRQ_ENABLE: hblank_irq_en_reg  <= cfg.data[0];
                CFG_VBLANK_IRQ_ENABLE: vblank_irq_en_reg  <= cfg.data[0];
                CFG_OAM_IRQ_ENABLE:    oam_irq_en_reg     <= cfg.data[0];
                CFG_COMPARE_IRQ_EN:    compare_irq_en_reg <= cfg.data[0];
                CFG_COMPARE_LINE:      compare_line_reg   <= cfg.data;
                default: ;
            endcase
        end
    end

    assign dot_sum    = dot_count_reg + {2'b00, in_ch.elapsed_cycles};
    assign line_inc   = line_count_reg + 8'd1;
    assign match_inc  = (line_inc == compare_line_reg);
    assign match_zero = (compare_line_reg == '0);

    always_comb
    begin
        dot_count_next  = dot_sum;
        line_count_next = line_count_reg;
        mode_next       = mode_reg;
        coinc_next      = coinc_reg;
        vblank_next     = 1'b0;
        stat_next       = 1'b0;
        draw_next       = 1'b0;
        if (!lcd_enable_reg)
        begin
            dot_count_next  = '0;
            line_count_next = '0;
            mode_next       = MODE_HBLANK;
        end
        else
        begin
            unique case (mode_reg)
                MODE_HBLANK:
                begin
                    if (dot_sum >= DOTS_HBLANK)
                    begin
                        dot_count_next  = '0;
                        line_count_next = line_inc;
                        coinc_next      = match_inc;
                        if (line_inc == LINE_VBLANK)
                        begin
                            mode_next   = MODE_VBLANK;
                            vblank_next = 1'b1;
                            stat_next   = (compare_irq_en_reg && match_inc)
                                          || vblank_irq_en_reg;
                        end
                        else
                        begin
                            mode_next = MODE_OAM;
                            stat_next = (compare_irq_en_reg && match_inc)
                                        || oam_irq_en_reg;
                        end
                    end
                end
                MODE_VBLANK:
                begin
                    if (dot_sum >= DOTS_LINE)
                    begin
                        dot_count_next  = '0;
                        line_count_next = line_inc;
                        coinc_next      = match_inc;
                        stat_next       = compare_irq_en_reg && match_inc;
                        if (line_inc == LINE_WRAP)
                        begin
                            // wrap to line 0 and compare again
                            line_count_next = '0;
                            coinc_next      = match_zero;
                            stat_next       = compare_irq_en_reg
                                              && (match_inc || match_zero);
                        end
                        else if (line_inc == LINE_FIRST)
                        begin
                            // hold line 0 for a second line time
                            line_count_next = '0;
                            mode_next       = MODE_OAM;
                            stat_next       = (compare_irq_en_reg && match_inc)
                                              || oam_irq_en_reg;
                        end
                    end
                end
                MODE_OAM:
                begin
                    if (dot_sum >= DOTS_OAM)
                    begin
                        dot_count_next = '0;
                        mode_next      = MODE_XFER;
                    end
                end
                MODE_XFER:
                begin
                    if (dot_sum >= DOTS_XFER)
                    begin
                        dot_count_next = '0;
                        mode_next      = MODE_HBLANK;
                        stat_next      = hblank_irq_en_reg;
                        draw_next      = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_count_reg  <= '0;
            line_count_reg <= '0;
            mode_reg       <= MODE_HBLANK;
            coinc_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            out_valid_reg <= in_fire || (out_valid_reg && !out_ch.ready);
            if (in_fire)
            begin
                dot_count_reg  <= dot_count_next;
                line_count_reg <= line_count_next;
                mode_reg       <= mode_next;
                coinc_reg      <= coinc_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_mode_reg   <= mode_next;
            out_line_reg   <= line_count_next;
            out_coinc_reg  <= coinc_next;
            out_vblank_reg <= vblank_next;
            out_stat_reg   <= stat_next;
            out_draw_reg   <= draw_next;
        end
    end

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.lcd_mode     = out_mode_reg;
    assign out_ch.current_line = out_line_reg;
    assign out_ch.coincidence  = out_coinc_reg;
    assign out_ch.vblank_irq   = out_vblank_reg;
    assign out_ch.stat_irq     = out_stat_reg;
    assign out_ch.draw_line    = out_draw_reg;

endmodule

`default_nettype wire

// ===== rtl/lmt_checker.sv =====
`default_nettype none

`include "lcd_mode_timing_top_defines.svh"

module lmt_checker
    import lmt_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [1:0]  lcd_mode,
    input wire logic [7:0]  current_line,
    input wire logic        coincidence,
    input wire logic        vblank_irq,
    input wire logic        stat_irq,
    input wire logic        draw_line
);

    logic [13:0] payload;

    assign payload = {lcd_mode, current_line, coincidence, vblank_irq, stat_irq, draw_line};

    `LMT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(payload), "stalled result changed")
    `LMT_ASSERT(a_ready_when_empty, !out_valid |-> in_ready, "input not ready with empty output")
    `LMT_ASSERT(a_line_range, out_valid |-> (current_line <= LINE_WRAP), "line beyond frame end")
    `LMT_ASSERT(a_vblank_entry, (out_valid && vblank_irq) |-> (lcd_mode == MODE_VBLANK && current_line == LINE_VBLANK), "VBlank pulse outside VBlank entry")
    `LMT_ASSERT(a_draw_mode, (out_valid && draw_line) |-> (lcd_mode == MODE_HBLANK && !vblank_irq), "draw pulse outside HBlank entry")

endmodule

bind lcd_mode_timing_top lmt_checker u_lmt_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ready     (in_ch.ready),
    .out_valid    (out_ch.valid),
    .out_ready    (out_ch.ready),
    .lcd_mode     (out_ch.lcd_mode),
    .current_line (out_ch.current_line),
    .coincidence  (out_ch.coincidence),
    .vblank_irq   (out_ch.vblank_irq),
    .stat_irq     (out_ch.stat_irq),
    .draw_line    (out_ch.draw_line)
);

`default_nettype wire

// ===== bench/lcd_mode_timing_top_tb.sv =====
`default_nettype none

module lcd_mode_timing_top_tb;
    import lmt_pkg::*;

    typedef struct packed {
        lcd_mode_t  mode;
        logic [7:0] line;
        logic       coin;
        logic       vblank;
        logic       stat;
        logic       draw;
    } lcd_status_t;

    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [7:0]           value;
        logic                 has_status;
        lcd_status_t          status;
    } stim_row_t;

    localparam int unsigned RANDOM_ITEMS = 1430;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned HOLD_AT_ITEM = 500;
    localparam lcd_status_t BLANKED = '{MODE_HBLANK, 8'd0, 1'b0, 1'b0, 1'b0, 1'b0};

    logic clk = 1'b0;
    logic rst_n;

    lmt_in_if  in_ch();
    lmt_out_if out_ch();
    lmt_cfg_if cfg();

    lcd_mode_timing_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor copy of the configuration and timing state
    logic            lcd_on       = 1'b0;
    logic            hblank_irq_on = 1'b0;
    logic            vblank_irq_on = 1'b0;
    logic            oam_irq_on    = 1'b0;
    logic            match_irq_on  = 1'b0;
    logic [7:0]      match_line    = 8'd0;
    logic [DOT_W-1:0] dots         = '0;
    logic [7:0]      scan_line     = 8'd0;
    lcd_mode_t       cur_mode      = MODE_HBLANK;
    logic            coin_flag     = 1'b0;

    lcd_status_t expected_status_q[$];
    logic        row_has_status_q[$];
    lcd_status_t row_status_q[$];

    int unsigned items_accepted = 0;
    int unsigned results_taken  = 0;
    int unsigned errors         = 0;
    bit          calm           = 1'b0;
    bit          hold_req       = 1'b0;

    function automatic logic compare_scan_line();
        coin_flag = (scan_line == match_line);
        return match_irq_on && coin_flag;
    endfunction

    function automatic lcd_status_t advance_timing(input logic [7:0] cycles);
        lcd_status_t s;
        s = BLANKED;
        dots = dots + DOT_W'(cycles);
        if (!lcd_on)
        begin
            dots = '0;
            scan_line = 8'd0;
            cur_mode = MODE_HBLANK;
        end
        else
        begin
            case (cur_mode)
                MODE_HBLANK:
                    if (dots >= DOTS_HBLANK)
                    begin
                        dots = '0;
                        scan_line = scan_line + 8'd1;
                        s.stat = compare_scan_line();
                        if (scan_line == LINE_VBLANK)
                        begin
                            cur_mode = MODE_VBLANK;
                            if (vblank_irq_on) s.stat = 1'b1;
                            s.vblank = 1'b1;
                        end
                        else
                        begin
                            cur_mode = MODE_OAM;
                            if (oam_irq_on) s.stat = 1'b1;
                        end
                    end
                MODE_VBLANK:
                    if (dots >= DOTS_LINE)
                    begin
                        dots = '0;
                        scan_line = scan_line + 8'd1;
                        s.stat = compare_scan_line();
                        if (scan_line == LINE_WRAP)
                        begin
                            scan_line = 8'd0;
                            s.stat = compare_scan_line() | s.stat;
                        end
                        else if (scan_line == LINE_FIRST)
                        begin
                            cur_mode = MODE_OAM;
                            if (oam_irq_on) s.stat = 1'b1;
                            scan_line = 8'd0;
                        end
                    end
                MODE_OAM:
                    if (dots >= DOTS_OAM)
                    begin
                        dots = '0;
                        cur_mode = MODE_XFER;
                    end
                default:
                    if (dots >= DOTS_XFER)
                    begin
                        dots = '0;
                        cur_mode = MODE_HBLANK;
                        if (hblank_irq_on) s.stat = 1'b1;
                        s.draw = 1'b1;
                    end
            endcase
        end
        s.mode = cur_mode;
        s.line = scan_line;
        s.coin = coin_flag;
        return s;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_flag(input logic b);
        logic [7:0] d;
        d = 8'($urandom_range(0, 255));
        d[0] = b;
        return d;
    endfunction

    function automatic stim_row_t step_row(input logic [7:0] c);
        stim_row_t r;
        r = '0;
        r.value = c;
        return r;
    endfunction

    function automatic stim_row_t blanked_row(input logic [7:0] c);
        stim_row_t r;
        r = step_row(c);
        r.has_status = 1'b1;
        r.status = BLANKED;
        return r;
    endfunction

    function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
        stim_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.value = d;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] e, input logic [7:0] g);
        if (g !== e)
        begin
            $display("%0t: %s expected %0d got %0d", $time, name, e, g);
            errors++;
        end
    endtask

    task automatic send_item(input logic [7:0] c, input logic has, input lcd_status_t st);
        int unsigned gap;
        row_has_status_q.push_back(has);
        row_status_q.push_back(st);
        in_ch.valid <= 1'b1;
        in_ch.elapsed_cycles <= c;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        items_accepted++;
        gap = idle_len();
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        while (results_taken != items_accepted) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] d);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= d;
        do @(posedge clk); while (cfg.ready !== 1'b1);
        cfg.valid <= 1'b0;
        @(posedge clk);
    endtask

    // receiver side: random stalls, one long hold-off
    initial
    begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end
            if (stall_left != 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                out_ch.ready <= 1'b1;
                stall_left = idle_len();
            end
        end
    end

    always @(posedge clk)
    begin : monitor
        lcd_status_t predicted;
        lcd_status_t e;
        logic        has;
        lcd_status_t typed;
        if (rst_n)
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_LCD_ENABLE:        lcd_on = cfg.data[0];
                    CFG_HBLANK_IRQ_ENABLE: hblank_irq_on = cfg.data[0];
                    CFG_VBLANK_IRQ_ENABLE: vblank_irq_on = cfg.data[0];
                    CFG_OAM_IRQ_ENABLE:    oam_irq_on = cfg.data[0];
                    CFG_COMPARE_IRQ_EN:    match_irq_on = cfg.data[0];
                    CFG_COMPARE_LINE:      match_line = cfg.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                predicted = advance_timing(in_ch.elapsed_cycles);
                has = row_has_status_q.pop_front();
                typed = row_status_q.pop_front();
                expected_status_q.push_back(has ? typed : predicted);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                results_taken++;
                if (expected_status_q.size() == 0)
                begin
                    $display("%0t: unexpected result, mode %0d line %0d", $time,
                             out_ch.lcd_mode, out_ch.current_line);
                    errors++;
                end
                else
                begin
                    e = expected_status_q.pop_front();
                    check_field("lcd_mode", 8'(e.mode), 8'(out_ch.lcd_mode));
                    check_field("current_line", e.line, out_ch.current_line);
                    check_field("coincidence", 8'(e.coin), 8'(out_ch.coincidence));
                    check_field("vblank_irq", 8'(e.vblank), 8'(out_ch.vblank_irq));
                    check_field("stat_irq", 8'(e.stat), 8'(out_ch.stat_irq));
                    check_field("draw_line", 8'(e.draw), 8'(out_ch.draw_line));
                end
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t   rows[$];
        int unsigned sent;
        int unsigned phase_len;
        int unsigned r;
        logic        en_bit;
        logic [7:0]  c;

        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.elapsed_cycles <= 8'd0;
        cfg.valid <= 1'b0;
        cfg.index <= CFG_LCD_ENABLE;
        cfg.data <= 8'd0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        rows = '{
            blanked_row(8'd0),
            blanked_row(8'd255),
            reg_row(CFG_COMPARE_LINE, 8'd1),
            reg_row(CFG_HBLANK_IRQ_ENABLE, 8'd1),
            reg_row(CFG_VBLANK_IRQ_ENABLE, 8'd1),
            reg_row(CFG_OAM_IRQ_ENABLE, 8'd1),
            reg_row(CFG_COMPARE_IRQ_EN, 8'd1),
            reg_row(CFG_LCD_ENABLE, 8'd1),
            step_row(8'd203),
            step_row(8'd1),
            step_row(8'd79),
            step_row(8'd1),
            step_row(8'd171),
            step_row(8'd1),
            step_row(8'd255),
            step_row(8'd128),
            step_row(8'd255),
            reg_row(CFG_HBLANK_IRQ_ENABLE, 8'hFE),
            reg_row(CFG_OAM_IRQ_ENABLE, 8'hFE),
            step_row(8'd204),
            step_row(8'd80),
            step_row(8'd172),
            reg_row(CFG_LCD_ENABLE, 8'hFE),
            step_row(8'd255),
            step_row(8'd0),
            reg_row(CFG_COMPARE_LINE, 8'd255),
            reg_row(CFG_LCD_ENABLE, 8'd1),
            step_row(8'd0),
            step_row(8'd255)
        };

        foreach (rows[i])
        begin
            if (rows[i].is_write)
            begin
                wait_idle();
                write_reg(rows[i].reg_idx, rows[i].value);
            end
            else
                send_item(rows[i].value, rows[i].has_status, rows[i].status);
        end

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            wait_idle();
            write_reg(CFG_HBLANK_IRQ_ENABLE, rand_flag(1'($urandom_range(0, 1))));
            write_reg(CFG_VBLANK_IRQ_ENABLE, rand_flag(1'($urandom_range(0, 1))));
            write_reg(CFG_OAM_IRQ_ENABLE, rand_flag(1'($urandom_range(0, 1))));
            write_reg(CFG_COMPARE_IRQ_EN, rand_flag(1'($urandom_range(0, 1))));
            case ($urandom_range(0, 7))
                0: c = 8'd0;
                1: c = LINE_FIRST;
                2: c = LINE_VBLANK - 8'd1;
                3: c = LINE_VBLANK;
                4: c = LINE_WRAP - 8'd1;
                5: c = LINE_WRAP;
                6: c = 8'd255;
                default: c = 8'($urandom_range(0, 255));
            endcase
            write_reg(CFG_COMPARE_LINE, c);
            en_bit = ($urandom_range(0, 7) != 0);
            write_reg(CFG_LCD_ENABLE, rand_flag(en_bit));
            calm = ($urandom_range(0, 3) == 0);
            phase_len = en_bit ? $urandom_range(150, 450) : $urandom_range(3, 12);
            for (int unsigned k = 0; k < phase_len && sent < RANDOM_ITEMS; k++)
            begin
                r = $urandom_range(0, 9);
                if (r == 0)
                    c = 8'd0;
                else if (r == 1)
                    c = 8'd255;
                else
                    c = 8'($urandom_range(0, 255));
                send_item(c, 1'b0, BLANKED);
                sent++;
                if (sent == HOLD_AT_ITEM) hold_req = 1'b1;
            end
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (errors == 0)
            $display("lcd_mode_timing_top_tb: PASS");
        else
            $display("lcd_mode_timing_top_tb: FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #5000000;
        $display("lcd_mode_timing_top_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
